// ===== hw/rtl/swls_pkg.sv =====
// Shared types and constants for the sliding-window latency statistics block.
package swls_pkg;

  localparam int unsigned WindowDepthDefault = 32;
  localparam int unsigned SampleW            = 16;
  localparam int unsigned CountOutW          = 6;

  localparam logic [SampleW-1:0] SampleMax = '1;

  typedef enum logic {
    MODE_ADD   = 1'b0,
    MODE_CLEAR = 1'b1
  } mode_e;

  typedef struct packed {
    logic capture;
    logic fetch;
    logic update;
    logic start;
    logic scan;
    logic load_out;
  } swls_cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_last;
    logic div_busy;
  } swls_status_t;

endpackage

// ===== hw/rtl/sliding_window_latency_stats.sv =====
// Top level of the sliding-window latency statistics block.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one item: mode_i = 0 adds
//   sample_i to a window of the WINDOW_DEPTH most recent samples, mode_i = 1
//   clears the window. Every item yields exactly one result on the output
//   channel (out_valid_o / out_ready_i): minimum, maximum, floor average,
//   jitter (maximum minus minimum) and the sample count (low 6 bits). All
//   statistics read zero while the window is empty.
//   Steps: an accepted item passes the fetch, update and start states, then, when
//   the window is not empty, a ring scan and a drain, and waits in hold for the divider.
//   The ring is scanned one slot per cycle through its single read port, while a
//   radix-2 divider produces one average bit per cycle alongside it.
//   Throughput: one item at a time; the next item is taken once the result
//   has moved to the output register.
//   A stalled receiver holds the result in the output register; the block
//   still accepts and works on one further item, then waits.
//   Reset empties the window; ring contents are not cleared and are only
//   read after being written.
module sliding_window_latency_stats
  import swls_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = WindowDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 mode_i,
  input  logic [SampleW-1:0]   sample_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SampleW-1:0]   min_value_o,
  output logic [SampleW-1:0]   max_value_o,
  output logic [SampleW-1:0]   average_o,
  output logic [SampleW-1:0]   jitter_o,
  output logic [CountOutW-1:0] sample_count_o
);

  swls_cmd_t    cmd;
  swls_status_t status;

  swls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  swls_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .mode_i         (mode_i),
    .sample_i       (sample_i),
    .min_value_o    (min_value_o),
    .max_value_o    (max_value_o),
    .average_o      (average_o),
    .jitter_o       (jitter_o),
    .sample_count_o (sample_count_o)
  );

`ifndef SYNTH
  property p_busy_after_accept;
    @(posedge clk_i) disable iff (!rst_ni)
      (in_valid_i && in_ready_o) |=> !in_ready_o;
  endproperty
  a_busy_after_accept: assert property (p_busy_after_accept)
    else $error("input accepted again while an item is in work");

  property p_min_le_max;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> (min_value_o <= max_value_o);
  endproperty
  a_min_le_max: assert property (p_min_le_max)
    else $error("minimum above maximum");

  property p_jitter_span;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> (jitter_o == max_value_o - min_value_o);
  endproperty
  a_jitter_span: assert property (p_jitter_span)
    else $error("jitter does not match max minus min");
`endif

endmodule

// ===== hw/rtl/swls_ctrl.sv =====
// Sequencer for the window statistics: update, ring scan, divide, result hand-off.
module swls_ctrl
  import swls_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  swls_status_t status_i,
  output swls_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_UPDATE,
    ST_START,
    ST_SCAN,
    ST_DRAIN,
    ST_HOLD
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  always_comb begin
    cmd_o      = '0;
    in_ready_o = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE:   cmd_o.capture  = in_valid_i;
      ST_FETCH:  cmd_o.fetch    = 1'b1;
      ST_UPDATE: cmd_o.update   = 1'b1;
      ST_START:  cmd_o.start    = 1'b1;
      ST_SCAN:   cmd_o.scan     = 1'b1;
      ST_DRAIN:  cmd_o          = '0;
      ST_HOLD:   cmd_o.load_out = !status_i.div_busy && (!out_valid_q || out_ready_i);
      default:   cmd_o          = '0;
    endcase
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_FETCH;
        end
        ST_FETCH:  state_q <= ST_UPDATE;
        ST_UPDATE: state_q <= ST_START;
        ST_START: begin
          state_q <= status_i.empty ? ST_HOLD : ST_SCAN;
        end
        ST_SCAN: begin
          if (status_i.scan_last) state_q <= ST_DRAIN;
        end
        ST_DRAIN: state_q <= ST_HOLD;
        ST_HOLD: begin
          if (cmd_o.load_out) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/swls_datapath.sv =====
// Sample ring, running sum, min/max scan, serial divider and result registers.
module swls_datapath
  import swls_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = WindowDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  swls_cmd_t            cmd_i,
  output swls_status_t         status_o,
  input  logic                 mode_i,
  input  logic [SampleW-1:0]   sample_i,
  output logic [SampleW-1:0]   min_value_o,
  output logic [SampleW-1:0]   max_value_o,
  output logic [SampleW-1:0]   average_o,
  output logic [SampleW-1:0]   jitter_o,
  output logic [CountOutW-1:0] sample_count_o
);

  localparam int unsigned PosW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SumW  = SampleW + CntW;
  localparam int unsigned StepW = $clog2(SampleW);
  localparam logic [PosW-1:0]  PosLast  = PosW'(WINDOW_DEPTH - 1);
  localparam logic [CntW-1:0]  CntFull  = CntW'(WINDOW_DEPTH);
  localparam logic [StepW-1:0] StepLast = StepW'(SampleW - 1);

  logic [SampleW-1:0] ring_q [WINDOW_DEPTH];
  logic [SampleW-1:0] rd_data_q;
  logic [PosW-1:0]    rd_addr;

  logic               mode_q;
  logic [SampleW-1:0] sample_q;
  logic [PosW-1:0]    pos_q;
  logic [CntW-1:0]    count_q;
  logic [SumW-1:0]    sum_q;
  logic [PosW-1:0]    idx_q;
  logic               cmp_valid_q;
  logic [SampleW-1:0] min_q;
  logic [SampleW-1:0] max_q;

  logic               div_busy_q;
  logic [StepW-1:0]   step_q;
  logic [CntW-1:0]    rem_q;
  logic [SampleW-1:0] quo_q;
  logic [CntW:0]      trial;
  logic               trial_ge;

  logic               full;
  logic [SumW-1:0]    sum_d;

  assign full    = (count_q == CntFull);
  assign rd_addr = cmd_i.fetch ? pos_q : idx_q;

  always_comb begin
    sum_d = sum_q + SumW'(sample_q);
    if (full) sum_d = sum_d - SumW'(rd_data_q);
  end

  assign trial    = {rem_q, quo_q[SampleW-1]};
  assign trial_ge = (trial >= {1'b0, count_q});

  assign status_o.empty     = (count_q == '0);
  assign status_o.scan_last = (CntW'(idx_q) == count_q - CntW'(1));
  assign status_o.div_busy  = div_busy_q;

  always_ff @(posedge clk_i) begin
    rd_data_q <= ring_q[rd_addr];
    if (cmd_i.update && (mode_q == MODE_ADD)) begin
      ring_q[pos_q] <= sample_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q   <= mode_i;
      sample_q <= sample_i;
    end
    if (cmd_i.start) begin
      min_q <= SampleMax;
      max_q <= '0;
    end else if (cmp_valid_q) begin
      if (rd_data_q < min_q) min_q <= rd_data_q;
      if (rd_data_q > max_q) max_q <= rd_data_q;
    end
    if (cmd_i.start) begin
      rem_q <= sum_q[SumW-1:SampleW];
      quo_q <= sum_q[SampleW-1:0];
    end else if (div_busy_q) begin
      rem_q <= trial_ge ? CntW'(trial - {1'b0, count_q}) : CntW'(trial);
      quo_q <= {quo_q[SampleW-2:0], trial_ge};
    end
    if (cmd_i.load_out) begin
      if (count_q == '0) begin
        min_value_o <= '0;
        max_value_o <= '0;
        average_o   <= '0;
        jitter_o    <= '0;
      end else begin
        min_value_o <= min_q;
        max_value_o <= max_q;
        average_o   <= quo_q;
        jitter_o    <= max_q - min_q;
      end
      sample_count_o <= CountOutW'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      idx_q       <= '0;
      cmp_valid_q <= 1'b0;
      div_busy_q  <= 1'b0;
      step_q      <= '0;
    end else begin
      if (cmd_i.update) begin
        if (mode_q == MODE_CLEAR) begin
          pos_q   <= '0;
          count_q <= '0;
          sum_q   <= '0;
        end else begin
          pos_q <= (pos_q == PosLast) ? '0 : pos_q + PosW'(1);
          sum_q <= sum_d;
          if (!full) count_q <= count_q + CntW'(1);
        end
      end
      if (cmd_i.start) begin
        idx_q <= '0;
      end else if (cmd_i.scan) begin
        idx_q <= idx_q + PosW'(1);
      end
      cmp_valid_q <= cmd_i.scan;
      if (cmd_i.start && (count_q != '0)) begin
        div_busy_q <= 1'b1;
        step_q     <= '0;
      end else if (div_busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepLast) div_busy_q <= 1'b0;
      end
    end
  end

endmodule

// ===== bench/swls_window_checker.sv =====
// Checker for the sliding-window latency statistics block: predicts and compares each result.
module swls_window_checker
  import swls_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 mode_i,
  input  logic [SampleW-1:0]   sample_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [SampleW-1:0]   min_value_i,
  input  logic [SampleW-1:0]   max_value_i,
  input  logic [SampleW-1:0]   average_i,
  input  logic [SampleW-1:0]   jitter_i,
  input  logic [CountOutW-1:0] sample_count_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = WindowDepthDefault;

  typedef struct packed {
    logic [SampleW-1:0]   min_value;
    logic [SampleW-1:0]   max_value;
    logic [SampleW-1:0]   average;
    logic [SampleW-1:0]   jitter;
    logic [CountOutW-1:0] sample_count;
  } window_stats_t;

  logic [SampleW-1:0] sample_ring [Depth];
  logic [4:0]         write_slot;
  logic [7:0]         fill_level;
  logic [20:0]        window_sum;
  window_stats_t      expected_stats_q [$];

  function automatic window_stats_t apply_item(logic clear, logic [SampleW-1:0] value);
    window_stats_t stats;
    logic [SampleW-1:0] lo;
    logic [SampleW-1:0] hi;
    logic [20:0] quotient;
    if (clear) begin
      fill_level = '0;
      write_slot = '0;
      window_sum = '0;
    end else begin
      if (fill_level >= Depth) window_sum = window_sum - sample_ring[write_slot];
      else fill_level = fill_level + 1'b1;
      sample_ring[write_slot] = value;
      window_sum = window_sum + value;
      write_slot = (write_slot == Depth - 1) ? '0 : write_slot + 1'b1;
    end
    stats = '0;
    if (fill_level != 0) begin
      lo = SampleMax;
      hi = '0;
      for (int i = 0; i < fill_level; i++) begin
        if (sample_ring[i] < lo) lo = sample_ring[i];
        if (sample_ring[i] > hi) hi = sample_ring[i];
      end
      quotient = window_sum / fill_level;
      stats.min_value = lo;
      stats.max_value = hi;
      stats.average   = (quotient > SampleMax) ? SampleMax : quotient[SampleW-1:0];
      stats.jitter    = hi - lo;
    end
    stats.sample_count = fill_level[CountOutW-1:0];
    return stats;
  endfunction

  function automatic void check_field(string field, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", field, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    window_stats_t exp_stats;
    if (!rst_ni) begin
      write_slot = '0;
      fill_level = '0;
      window_sum = '0;
      expected_stats_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_stats_q.size() == 0) begin
          $error("result with no item pending");
          fail_count_o++;
        end else begin
          exp_stats = expected_stats_q.pop_front();
          check_field("min_value", exp_stats.min_value, min_value_i);
          check_field("max_value", exp_stats.max_value, max_value_i);
          check_field("average", exp_stats.average, average_i);
          check_field("jitter", exp_stats.jitter, jitter_i);
          check_field("sample_count", exp_stats.sample_count, sample_count_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_stats_q.push_back(apply_item(mode_i == MODE_CLEAR, sample_i));
      end
    end
    pending_o = expected_stats_q.size();
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the sliding-window latency statistics bench: stimulus, idling, watchdog and verdict.
module testbench
  import swls_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 5000;
  localparam int HoldOffCycles = 400;

  typedef enum int {
    STYLE_ANY,
    STYLE_HIGH,
    STYLE_LOW,
    STYLE_EXTREME
  } sample_style_e;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  mode_e                mode;
  logic [SampleW-1:0]   sample;
  logic                 out_valid;
  logic                 out_ready;
  logic [SampleW-1:0]   min_value;
  logic [SampleW-1:0]   max_value;
  logic [SampleW-1:0]   average;
  logic [SampleW-1:0]   jitter;
  logic [CountOutW-1:0] sample_count;
  int                   fail_count;
  int                   pending;
  int                   send_idle_pct;
  int                   recv_stall_pct;
  logic                 hold_off_req;
  logic                 hold_off_done;
  int                   quiet_cycles;

  sliding_window_latency_stats DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (mode),
    .sample_i       (sample),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .min_value_o    (min_value),
    .max_value_o    (max_value),
    .average_o      (average),
    .jitter_o       (jitter),
    .sample_count_o (sample_count)
  );

  swls_window_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .mode_i         (mode),
    .sample_i       (sample),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .min_value_i    (min_value),
    .max_value_i    (max_value),
    .average_i      (average),
    .jitter_i       (jitter),
    .sample_count_i (sample_count),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    hold_off_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk);
        hold_off_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(mode_e item_mode, logic [SampleW-1:0] item_sample);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= item_mode;
    sample   <= item_sample;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic [SampleW-1:0] pick_sample(sample_style_e style);
    case (style)
      STYLE_HIGH:    return SampleMax - SampleW'($urandom_range(3));
      STYLE_LOW:     return SampleW'($urandom_range(15));
      STYLE_EXTREME: return $urandom_range(1) ? SampleMax : '0;
      default:       return SampleW'($urandom);
    endcase
  endfunction

  // Runs of 20 to 90 adds, often long enough to fill and wrap the window, with a few stray clears.
  task automatic send_random(int n_items);
    int sent;
    int run_len;
    sample_style_e style;
    sent = 0;
    while (sent < n_items) begin
      run_len = $urandom_range(90, 20);
      style   = sample_style_e'($urandom_range(3));
      if ($urandom_range(2) == 0) begin
        send_item(MODE_CLEAR, SampleW'($urandom));
        sent++;
      end
      for (int i = 0; i < run_len && sent < n_items; i++) begin
        if ($urandom_range(49) == 0) send_item(MODE_CLEAR, SampleW'($urandom));
        else send_item(MODE_ADD, pick_sample(style));
        sent++;
      end
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    mode           <= MODE_ADD;
    sample         <= '0;
    hold_off_req   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(MODE_CLEAR, 16'h0000);
    send_item(MODE_ADD, 16'h0000);
    send_item(MODE_ADD, 16'hFFFF);
    send_item(MODE_ADD, 16'h0001);
    send_item(MODE_ADD, 16'hFFFE);
    send_item(MODE_ADD, 16'h5555);
    send_item(MODE_ADD, 16'hAAAA);
    send_item(MODE_CLEAR, 16'hFFFF);
    send_item(MODE_CLEAR, 16'h1234);
    send_item(MODE_ADD, 16'hFFFF);
    send_item(MODE_ADD, 16'hFFFF);
    send_item(MODE_CLEAR, 16'h0000);
    send_item(MODE_ADD, 16'h8000);
    send_item(MODE_ADD, 16'h7FFF);
    send_item(MODE_ADD, 16'h0000);
    send_item(MODE_CLEAR, 16'hAAAA);

    // Hold the receiver off while items keep coming so the block backs up.
    hold_off_req = 1'b1;
    for (int i = 0; i < 8; i++) send_item(MODE_ADD, SampleW'($urandom));

    send_random(175);
    send_idle_pct = 70;
    send_random(175);
    send_idle_pct  = 0;
    recv_stall_pct = 70;
    send_random(175);
    send_idle_pct  = 13;
    recv_stall_pct = 13;
    send_random(175);
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sliding_window_latency_stats.f =====
hw/rtl/swls_pkg.sv
hw/rtl/swls_ctrl.sv
hw/rtl/swls_datapath.sv
hw/rtl/sliding_window_latency_stats.sv
bench/swls_window_checker.sv
bench/testbench.sv
